### hw/rtl/sfpd_pkg.sv
// Shared constants, types and command/status codes for the searchable FIFO.
package sfpd_pkg;

   localparam int DEPTH = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int POS_W = 5;
   localparam int STAT_W = 3;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_DELETE  = 2'd2,
      CMD_SEARCH  = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_BAD_POS   = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECIDE,
      FSM_READ,
      FSM_CHECK
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch;
      logic       enq;
      logic       rd;
      logic       wr_back;
      logic       head_inc;
      logic       count_dec;
      logic       idx_inc;
      logic       finish;
      logic       take_out;
      logic       take_match;
      status_type status;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    pos_bad;
      logic    idx_lt_count;
      logic    idx_last;
      logic    hit;
   } sts_type;

endpackage

### hw/rtl/sfpd_ctrl.sv
// Command sequencer: walks each command through a decide step and, where needed, read and check steps.
module sfpd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sfpd_pkg::sts_type  sts,
   output sfpd_pkg::ctl_type  ctl
);

   sfpd_pkg::fsm_type state_ff;
   sfpd_pkg::fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfpd_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfpd_pkg::FSM_IDLE: begin
            if (start) begin
               state_in = sfpd_pkg::FSM_DECIDE;
            end
         end
         sfpd_pkg::FSM_DECIDE: begin
            state_in = sfpd_pkg::FSM_IDLE;
            case (sts.cmd)
               sfpd_pkg::CMD_DEQUEUE: begin
                  if (!sts.empty) begin
                     state_in = sfpd_pkg::FSM_READ;
                  end
               end
               sfpd_pkg::CMD_DELETE: begin
                  if (!sts.pos_bad && sts.idx_lt_count) begin
                     state_in = sfpd_pkg::FSM_READ;
                  end
               end
               sfpd_pkg::CMD_SEARCH: begin
                  if (sts.idx_lt_count) begin
                     state_in = sfpd_pkg::FSM_READ;
                  end
               end
               default: begin
                  state_in = sfpd_pkg::FSM_IDLE;
               end
            endcase
         end
         sfpd_pkg::FSM_READ: begin
            state_in = sfpd_pkg::FSM_CHECK;
         end
         sfpd_pkg::FSM_CHECK: begin
            state_in = sfpd_pkg::FSM_IDLE;
            case (sts.cmd)
               sfpd_pkg::CMD_DELETE: begin
                  if (!sts.idx_last) begin
                     state_in = sfpd_pkg::FSM_READ;
                  end
               end
               sfpd_pkg::CMD_SEARCH: begin
                  if (!sts.hit && !sts.idx_last) begin
                     state_in = sfpd_pkg::FSM_READ;
                  end
               end
               default: begin
                  state_in = sfpd_pkg::FSM_IDLE;
               end
            endcase
         end
         default: begin
            state_in = sfpd_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.status = sfpd_pkg::STAT_OK;
      busy = (state_ff != sfpd_pkg::FSM_IDLE);
      case (state_ff)
         sfpd_pkg::FSM_IDLE: begin
            ctl.latch = start;
         end
         sfpd_pkg::FSM_DECIDE: begin
            case (sts.cmd)
               sfpd_pkg::CMD_ENQUEUE: begin
                  ctl.finish = 1'b1;
                  if (sts.full) begin
                     ctl.status = sfpd_pkg::STAT_FULL;
                  end else begin
                     ctl.enq = 1'b1;
                  end
               end
               sfpd_pkg::CMD_DEQUEUE: begin
                  if (sts.empty) begin
                     ctl.finish = 1'b1;
                     ctl.status = sfpd_pkg::STAT_EMPTY;
                  end
               end
               sfpd_pkg::CMD_DELETE: begin
                  if (sts.pos_bad) begin
                     ctl.finish = 1'b1;
                     ctl.status = sfpd_pkg::STAT_BAD_POS;
                  end else if (!sts.idx_lt_count) begin
                     // last entry: nothing to close up
                     ctl.finish = 1'b1;
                     ctl.count_dec = 1'b1;
                  end
               end
               sfpd_pkg::CMD_SEARCH: begin
                  if (!sts.idx_lt_count) begin
                     ctl.finish = 1'b1;
                     ctl.status = sfpd_pkg::STAT_NOT_FOUND;
                  end
               end
               default: begin
                  ctl.finish = 1'b0;
               end
            endcase
         end
         sfpd_pkg::FSM_READ: begin
            ctl.rd = 1'b1;
         end
         sfpd_pkg::FSM_CHECK: begin
            case (sts.cmd)
               sfpd_pkg::CMD_DEQUEUE: begin
                  ctl.finish = 1'b1;
                  ctl.take_out = 1'b1;
                  ctl.head_inc = 1'b1;
                  ctl.count_dec = 1'b1;
               end
               sfpd_pkg::CMD_DELETE: begin
                  ctl.wr_back = 1'b1;
                  if (sts.idx_last) begin
                     ctl.finish = 1'b1;
                     ctl.count_dec = 1'b1;
                  end else begin
                     ctl.idx_inc = 1'b1;
                  end
               end
               sfpd_pkg::CMD_SEARCH: begin
                  if (sts.hit) begin
                     ctl.finish = 1'b1;
                     ctl.take_match = 1'b1;
                  end else if (sts.idx_last) begin
                     ctl.finish = 1'b1;
                     ctl.status = sfpd_pkg::STAT_NOT_FOUND;
                  end else begin
                     ctl.idx_inc = 1'b1;
                  end
               end
               default: begin
                  ctl.finish = 1'b0;
               end
            endcase
         end
         default: begin
            ctl.finish = 1'b0;
         end
      endcase
   end

endmodule

### hw/rtl/sfpd_datapath.sv
// Datapath: circular entry memory, head/count/index registers and result registers.
module sfpd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_command,
   input  logic signed [sfpd_pkg::DATA_W-1:0]  req_value,
   input  logic [sfpd_pkg::POS_W-1:0]          req_position,
   input  sfpd_pkg::ctl_type                   ctl,
   output sfpd_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   output logic [sfpd_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [sfpd_pkg::DATA_W-1:0]  rsp_out_value,
   output logic [sfpd_pkg::POS_W-1:0]          rsp_match_position,
   output logic [sfpd_pkg::POS_W-1:0]          rsp_occupancy
);

   localparam int AW = sfpd_pkg::ADDR_W;
   localparam int CW = sfpd_pkg::CNT_W;
   localparam int DW = sfpd_pkg::DATA_W;
   localparam int PW = sfpd_pkg::POS_W;
   localparam int MW = sfpd_pkg::CMP_W;
   localparam logic [CW:0] DEPTH_S = (CW + 1)'(sfpd_pkg::DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(sfpd_pkg::DEPTH);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   logic signed [DW-1:0] mem [sfpd_pkg::DEPTH];

   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   sfpd_pkg::cmd_type    cmd_ff;
   logic signed [DW-1:0] value_ff;
   logic [PW-1:0]        pos_ff;
   logic signed [DW-1:0] rdata_ff;

   logic                 valid_ff;
   logic [sfpd_pkg::STAT_W-1:0] status_ff;
   logic signed [DW-1:0] out_ff;
   logic [PW-1:0]        match_ff;
   logic [PW-1:0]        occ_ff;

   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        tail_addr;
   logic [AW-1:0]        back_addr;
   logic [CW-1:0]        idx_plus;

   function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(offs);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[AW-1:0];
   endfunction

   assign idx_plus  = idx_ff + ONE_C;
   assign rd_addr   = wrap_addr(head_ff, idx_ff);
   assign tail_addr = wrap_addr(head_ff, count_ff);
   assign back_addr = wrap_addr(head_ff, idx_ff - ONE_C);
   assign wr_addr   = ctl.enq ? tail_addr : back_addr;

   always_ff @(posedge clock) begin
      if (ctl.enq || ctl.wr_back) begin
         mem[wr_addr] <= ctl.enq ? value_ff : rdata_ff;
      end
      if (ctl.rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      head_in = head_ff;
      if (ctl.head_inc) begin
         head_in = wrap_addr(head_ff, ONE_C);
      end
      count_in = count_ff;
      if (ctl.enq) begin
         count_in = count_ff + ONE_C;
      end else if (ctl.count_dec) begin
         count_in = count_ff - ONE_C;
      end
      idx_in = idx_ff;
      if (ctl.latch) begin
         idx_in = (req_command == sfpd_pkg::CMD_DELETE) ? CW'(req_position) : '0;
      end else if (ctl.idx_inc) begin
         idx_in = idx_plus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         valid_ff <= ctl.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff   <= sfpd_pkg::cmd_type'(req_command);
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (ctl.finish) begin
         status_ff <= ctl.status;
         out_ff    <= ctl.take_out ? rdata_ff : '0;
         match_ff  <= ctl.take_match ? PW'(idx_plus) : '0;
         occ_ff    <= PW'(count_in);
      end
   end

   assign sts.cmd          = cmd_ff;
   assign sts.full         = (count_ff >= DEPTH_C);
   assign sts.empty        = (count_ff == '0);
   assign sts.pos_bad      = (pos_ff == '0) || (MW'(pos_ff) > MW'(count_ff));
   assign sts.idx_lt_count = (idx_ff < count_ff);
   assign sts.idx_last     = (idx_plus >= count_ff);
   assign sts.hit          = (rdata_ff == value_ff);

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_value      = out_ff;
   assign rsp_match_position = match_ff;
   assign rsp_occupancy      = occ_ff;

endmodule

### hw/rtl/searchable_fifo_with_positional_delete_top.sv
// Searchable FIFO with positional delete: top level joining sequencer and datapath.
//
// Bounded queue of signed 32-bit words driven one command at a time. A command is
// taken when start is high and busy is low; its single result appears on the rsp_
// ports for exactly one cycle with rsp_valid high and cannot be held off, so the
// user must capture it then. Enqueue and any rejected command finish in the decide
// state; dequeue adds a read and a check state; delete at position p on n entries
// repeats read and check for each entry after p; a search repeats them until a hit
// or all n entries are examined, as the entry memory has a single read port whose
// read data is registered before compare or write-back. A new command may be
// started in the cycle that the previous result is on the outputs.
module searchable_fifo_with_positional_delete_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic signed [sfpd_pkg::DATA_W-1:0]  req_value,
   input  logic [sfpd_pkg::POS_W-1:0]          req_position,
   output logic                                rsp_valid,
   output logic [sfpd_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [sfpd_pkg::DATA_W-1:0]  rsp_out_value,
   output logic [sfpd_pkg::POS_W-1:0]          rsp_match_position,
   output logic [sfpd_pkg::POS_W-1:0]          rsp_occupancy
);

   sfpd_pkg::ctl_type ctl;
   sfpd_pkg::sts_type sts;

   sfpd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   sfpd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_command),
      .req_value          (req_value),
      .req_position       (req_position),
      .ctl                (ctl),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_value      (rsp_out_value),
      .rsp_match_position (rsp_match_position),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule
